[src/gifc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gifc_pkg
// Shared types and constants of the GPIO indication frame checker.
// ----------------------------------------------------------------------------
package gifc_pkg;

	localparam int CNT_W             = 6;
	localparam int LEN_W             = CNT_W + 1;
	localparam int PIN_W             = 6;
	localparam int MIN_FRAME_LEN_DEF = 32;

	localparam logic [CNT_W-1:0] OFF_TYPE0   = CNT_W'(12);
	localparam logic [CNT_W-1:0] OFF_TYPE1   = CNT_W'(13);
	localparam logic [CNT_W-1:0] OFF_VERSION = CNT_W'(14);
	localparam logic [CNT_W-1:0] OFF_OPC0    = CNT_W'(15);
	localparam logic [CNT_W-1:0] OFF_OPC1    = CNT_W'(16);
	localparam logic [CNT_W-1:0] OFF_VEND0   = CNT_W'(19);
	localparam logic [CNT_W-1:0] OFF_VEND1   = CNT_W'(20);
	localparam logic [CNT_W-1:0] OFF_VEND2   = CNT_W'(21);
	localparam logic [CNT_W-1:0] OFF_SUBVER  = CNT_W'(22);
	localparam logic [CNT_W-1:0] OFF_LEVELS  = CNT_W'(23);
	localparam logic [CNT_W-1:0] OFF_DIRS    = CNT_W'(24);

	localparam logic [7:0] TYPE0_VAL   = 8'h88;
	localparam logic [7:0] TYPE1_VAL   = 8'hE1;
	localparam logic [7:0] VERSION_VAL = 8'h01;
	localparam logic [7:0] OPC0_VAL    = 8'h02;
	localparam logic [7:0] OPC1_VAL    = 8'hA0;
	localparam logic [7:0] VEND0_VAL   = 8'h00;
	localparam logic [7:0] VEND1_VAL   = 8'h01;
	localparam logic [7:0] VEND2_VAL   = 8'h87;
	localparam logic [7:0] SUBVER_VAL  = 8'h00;
	localparam logic [7:0] RSVD_MASK   = 8'hC0;

	typedef enum logic [3:0] {
		FAULT_NONE    = 4'd0,
		FAULT_SHORT   = 4'd1,
		FAULT_TYPE    = 4'd2,
		FAULT_VERSION = 4'd3,
		FAULT_OPCODE  = 4'd4,
		FAULT_VENDOR  = 4'd5,
		FAULT_SUBVER  = 4'd6,
		FAULT_LEVELS  = 4'd7,
		FAULT_DIRS    = 4'd8
	} fault_t;

	typedef enum logic [1:0] {
		ST_APPLIED = 2'd0,
		ST_IGNORED = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		logic [PIN_W-1:0] sender_levels;
		logic [PIN_W-1:0] sender_dirs;
		logic [PIN_W-1:0] new_levels;
		fault_t           fault_reason;
		status_t          status;
	} result_t;

endpackage
`default_nettype wire

[src/gifc_frame_state.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gifc_frame_state
// Per-frame state and checks: byte offset, first fault, captured sender
// bytes and the kept output levels; forms the result of a last word.
// ----------------------------------------------------------------------------
module gifc_frame_state #(
	parameter int MIN_FRAME_LEN = gifc_pkg::MIN_FRAME_LEN_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 advance,
	input  wire [7:0]           frame_byte,
	input  wire                 last_byte,
	output gifc_pkg::result_t   result
);
	import gifc_pkg::*;

	localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_FRAME_LEN);

	logic [CNT_W-1:0] byte_count_q;
	fault_t           first_fault_q;
	logic [7:0]       captured_levels_q;
	logic [7:0]       captured_dirs_q;
	logic [PIN_W-1:0] output_levels_q;

	fault_t           byte_fault;
	fault_t           fault_next;
	logic [7:0]       levels_next;
	logic [7:0]       dirs_next;
	logic [LEN_W-1:0] len;
	logic             is_short;
	logic [PIN_W-1:0] lev;
	logic [PIN_W-1:0] dirs;
	logic [PIN_W-1:0] merged;

	always_comb begin
		byte_fault = FAULT_NONE;
		unique case (byte_count_q)
			OFF_TYPE0:   if (frame_byte != TYPE0_VAL)   byte_fault = FAULT_TYPE;
			OFF_TYPE1:   if (frame_byte != TYPE1_VAL)   byte_fault = FAULT_TYPE;
			OFF_VERSION: if (frame_byte != VERSION_VAL) byte_fault = FAULT_VERSION;
			OFF_OPC0:    if (frame_byte != OPC0_VAL)    byte_fault = FAULT_OPCODE;
			OFF_OPC1:    if (frame_byte != OPC1_VAL)    byte_fault = FAULT_OPCODE;
			OFF_VEND0:   if (frame_byte != VEND0_VAL)   byte_fault = FAULT_VENDOR;
			OFF_VEND1:   if (frame_byte != VEND1_VAL)   byte_fault = FAULT_VENDOR;
			OFF_VEND2:   if (frame_byte != VEND2_VAL)   byte_fault = FAULT_VENDOR;
			OFF_SUBVER:  if (frame_byte != SUBVER_VAL)  byte_fault = FAULT_SUBVER;
			OFF_LEVELS:  if ((frame_byte & RSVD_MASK) != 8'h00) byte_fault = FAULT_LEVELS;
			OFF_DIRS:    if ((frame_byte & RSVD_MASK) != RSVD_MASK) byte_fault = FAULT_DIRS;
			default:     byte_fault = FAULT_NONE;
		endcase
	end

	assign fault_next  = (first_fault_q == FAULT_NONE) ? byte_fault : first_fault_q;
	assign levels_next = (byte_count_q == OFF_LEVELS) ? frame_byte : captured_levels_q;
	assign dirs_next   = (byte_count_q == OFF_DIRS) ? frame_byte : captured_dirs_q;
	assign len         = {1'b0, byte_count_q} + LEN_W'(1);
	assign is_short    = len < MIN_LEN;
	assign lev         = levels_next[PIN_W-1:0];
	assign dirs        = dirs_next[PIN_W-1:0];
	assign merged      = (~dirs & lev) | (dirs & output_levels_q);

	always_comb begin
		result.sender_levels = lev;
		result.sender_dirs   = dirs;
		result.new_levels    = output_levels_q;
		priority if (is_short) begin
			result.status       = ST_IGNORED;
			result.fault_reason = FAULT_SHORT;
		end else if (fault_next == FAULT_NONE) begin
			result.status       = ST_APPLIED;
			result.fault_reason = FAULT_NONE;
			result.new_levels   = merged;
		end else if (fault_next <= FAULT_VENDOR) begin
			result.status       = ST_IGNORED;
			result.fault_reason = fault_next;
		end else begin
			result.status       = ST_INVALID;
			result.fault_reason = fault_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			first_fault_q     <= FAULT_NONE;
			captured_levels_q <= '0;
			captured_dirs_q   <= '0;
			output_levels_q   <= '0;
		end else if (advance) begin
			if (last_byte) begin
				byte_count_q      <= '0;
				first_fault_q     <= FAULT_NONE;
				captured_levels_q <= '0;
				captured_dirs_q   <= '0;
				output_levels_q   <= result.new_levels;
			end else begin
				byte_count_q      <= is_short ? len[CNT_W-1:0] : MIN_LEN[CNT_W-1:0];
				first_fault_q     <= fault_next;
				captured_levels_q <= levels_next;
				captured_dirs_q   <= dirs_next;
			end
		end
	end

endmodule
`default_nettype wire

[src/gpio_indication_frame_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_indication_frame_checker
// Checks a received GPIO indication frame word by word and reports the
// outcome on its last word, merging new output levels when applied.
// ----------------------------------------------------------------------------
// Path: input register, check/update stage, result register.
// Throughput: one word per cycle, set by the single check/update stage,
// but a last word waits in the input register while a result is unaccepted.
// Reset: arst_n clears the offset, fault, captured bytes, output levels and
// both valid flags at once; the block takes words in the first cycle after.
module gpio_indication_frame_checker #(
	parameter int MIN_FRAME_LEN = gifc_pkg::MIN_FRAME_LEN_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,  // [7:0] frame_byte
	input  wire         s_tlast,  // last_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata   // [1:0] status, [5:2] fault_reason, [11:6] new_levels,
	                              // [17:12] sender_dirs, [23:18] sender_levels
);
	import gifc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       fire_s1;
	logic       out_free;
	result_t    result;
	result_t    result_s2;
	logic       valid_s2;

	assign out_free = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	gifc_frame_state #(
		.MIN_FRAME_LEN(MIN_FRAME_LEN)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (fire_s1),
		.frame_byte(byte_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(fire_s1 && last_s1))
		else $error("result word without a last input word");

	a_applied_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s2.status == ST_APPLIED) |-> result_s2.fault_reason == FAULT_NONE)
		else $error("applied frame carries a fault");

	a_invalid_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s2.status == ST_INVALID) |->
		(result_s2.fault_reason == FAULT_SUBVER || result_s2.fault_reason == FAULT_LEVELS ||
		 result_s2.fault_reason == FAULT_DIRS))
		else $error("invalid status with a non-content fault");

endmodule
`default_nettype wire
